>>> sv/sbp_pkg.sv
// Shared types and constants of the scratch buffer pool.
// Used by the slot RAM, the fit check and the pool core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

    // Fixed field widths of the input and result words.
    localparam int TYPE_BITS   = 4;
    localparam int IN_DIM_BITS = 16;
    localparam int ID_BITS     = 4;
    localparam int STATUS_BITS = 3;

    // Requested action of an input word.
    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    // Status code of a result word.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_REUSED   = 3'd0,
        ST_CREATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_BADREL   = 3'd4
    } status_t;

endpackage

`default_nettype wire

>>> sv/sbp_slot_ram.sv
// Descriptor memory of the buffer pool: type code and two dimensions per slot.
// One write port, one registered read port; uses sbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbp_slot_ram #(
    parameter int DEPTH    = 16,
    parameter int DIM_W    = 16,
    parameter int ADDR_W   = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [sbp_pkg::TYPE_BITS-1:0] wr_type,
    input  wire logic [DIM_W-1:0]              wr_dim0,
    input  wire logic [DIM_W-1:0]              wr_dim1,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic      [sbp_pkg::TYPE_BITS-1:0] rd_type,
    output logic      [DIM_W-1:0]              rd_dim0,
    output logic      [DIM_W-1:0]              rd_dim1
);
    import sbp_pkg::*;

    localparam int ENTRY_W = TYPE_BITS + 2 * DIM_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write the descriptor of a newly created slot.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_type, wr_dim0, wr_dim1};
        end
    end

    // Registered read of the slot under scan.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_type = rd_data_reg[ENTRY_W-1 -: TYPE_BITS];
    assign rd_dim0 = rd_data_reg[2*DIM_W-1 -: DIM_W];
    assign rd_dim1 = rd_data_reg[DIM_W-1:0];

endmodule

`default_nettype wire

>>> sv/sbp_fit_check.sv
// Shared compare unit: decides whether one stored slot satisfies a request.
// Used once per scanned slot by the pool core; uses sbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbp_fit_check #(
    parameter int DIM_W = 16
) (
    input  wire logic                          entry_busy,
    input  wire logic [sbp_pkg::TYPE_BITS-1:0] entry_type,
    input  wire logic [DIM_W-1:0]              entry_dim0,
    input  wire logic [DIM_W-1:0]              entry_dim1,
    input  wire logic [sbp_pkg::TYPE_BITS-1:0] req_type,
    input  wire logic [DIM_W-1:0]              req_dim0,
    input  wire logic [DIM_W-1:0]              req_dim1,
    output logic                               fit
);
    import sbp_pkg::*;

    // An idle slot of the same type that is at least as large in both dimensions.
    assign fit = !entry_busy && (entry_type == req_type) &&
                 (entry_dim0 >= req_dim0) && (entry_dim1 >= req_dim1);

endmodule

`default_nettype wire

>>> sv/scratch_buffer_pool_core.sv
// Scratch buffer pool: first-fit slot grant with a busy flag per slot.
// Sequencing: a release loads its result word in S_RELEASE once the output register is free;
// an acquire reads one descriptor a cycle in S_SCAN, but a waiting result word holds the scan.
// One word is in work at a time; the next is taken in S_IDLE after the result is loaded.
// Synchronous active-low reset clears slot count, busy flags and handshake state only.
`timescale 1ns / 1ps
`default_nettype none

module scratch_buffer_pool_core #(
    parameter int POOL_SLOTS = 16,
    parameter int DIM_BITS   = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_action,
    input  wire logic [sbp_pkg::TYPE_BITS-1:0]    s_elem_type,
    input  wire logic [sbp_pkg::IN_DIM_BITS-1:0]  s_req_dim0,
    input  wire logic [sbp_pkg::IN_DIM_BITS-1:0]  s_req_dim1,
    input  wire logic [sbp_pkg::ID_BITS-1:0]      s_release_slot,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [sbp_pkg::ID_BITS-1:0]      m_slot_id,
    output logic      [sbp_pkg::STATUS_BITS-1:0]  m_status
);
    import sbp_pkg::*;

    // Stored dimensions keep only the bits that survive the modulo.
    localparam int DimW    = (DIM_BITS < IN_DIM_BITS) ? DIM_BITS : IN_DIM_BITS;
    localparam int IdxBits = $clog2(POOL_SLOTS);
    localparam int CntBits = $clog2(POOL_SLOTS + 1);
    localparam int CmpBits = (CntBits > ID_BITS) ? CntBits : ID_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RELEASE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CntBits-1:0]      used_reg, used_next;
    logic [POOL_SLOTS-1:0]   slot_busy_reg, slot_busy_next;
    logic [CntBits-1:0]      issue_reg, issue_next;
    logic [IdxBits-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                    pend_reg, pend_next;
    logic                    m_valid_reg, m_valid_next;
    logic [ID_BITS-1:0]      m_slot_id_reg, m_slot_id_next;
    status_t                 m_status_reg, m_status_next;

    // Captured request word.
    logic [TYPE_BITS-1:0]    type_reg, type_next;
    logic [DimW-1:0]         dim0_reg, dim0_next;
    logic [DimW-1:0]         dim1_reg, dim1_next;
    logic [ID_BITS-1:0]      rel_slot_reg, rel_slot_next;

    // Memory and compare unit connections.
    logic                    ram_wr_en;
    logic [IdxBits-1:0]      ram_wr_addr;
    logic                    ram_rd_en;
    logic [IdxBits-1:0]      ram_rd_addr;
    logic [TYPE_BITS-1:0]    ram_rd_type;
    logic [DimW-1:0]         ram_rd_dim0;
    logic [DimW-1:0]         ram_rd_dim1;
    logic                    fit;

    logic                    out_free;
    logic                    out_load;
    logic                    hit;
    logic                    scan_miss;
    logic [CmpBits-1:0]      rel_wide;
    logic [CmpBits-1:0]      used_wide;
    logic [CmpBits-1:0]      cmp_wide;
    logic [IdxBits-1:0]      rel_idx;
    logic                    rel_ok;

    sbp_slot_ram #(
        .DEPTH  (POOL_SLOTS),
        .DIM_W  (DimW),
        .ADDR_W (IdxBits)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_type (type_reg),
        .wr_dim0 (dim0_reg),
        .wr_dim1 (dim1_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_type (ram_rd_type),
        .rd_dim0 (ram_rd_dim0),
        .rd_dim1 (ram_rd_dim1)
    );

    sbp_fit_check #(
        .DIM_W (DimW)
    ) u_fit_check (
        .entry_busy (slot_busy_reg[cmp_idx_reg]),
        .entry_type (ram_rd_type),
        .entry_dim0 (ram_rd_dim0),
        .entry_dim1 (ram_rd_dim1),
        .req_type   (type_reg),
        .req_dim0   (dim0_reg),
        .req_dim1   (dim1_reg),
        .fit        (fit)
    );

    // Scan decisions and release checks.
    assign out_free  = !m_valid_reg || m_ready;
    assign hit       = pend_reg && fit;
    assign scan_miss = (!pend_reg || !fit) && (issue_reg == used_reg);
    assign rel_wide  = CmpBits'(rel_slot_reg);
    assign used_wide = CmpBits'(used_reg);
    assign cmp_wide  = CmpBits'(cmp_idx_reg);
    assign rel_idx   = rel_wide[IdxBits-1:0];
    assign rel_ok    = (rel_wide < used_wide) && slot_busy_reg[rel_idx];

    assign ram_wr_addr = used_reg[IdxBits-1:0];
    assign ram_rd_addr = issue_reg[IdxBits-1:0];

    // Sequencer next-state logic.
    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        slot_busy_next = slot_busy_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = pend_reg;
        m_slot_id_next = m_slot_id_reg;
        m_status_next  = m_status_reg;
        type_next      = type_reg;
        dim0_next      = dim0_reg;
        dim1_next      = dim1_reg;
        rel_slot_next  = rel_slot_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    type_next     = s_elem_type;
                    dim0_next     = s_req_dim0[DimW-1:0];
                    dim1_next     = s_req_dim1[DimW-1:0];
                    rel_slot_next = s_release_slot;
                    issue_next    = '0;
                    pend_next     = 1'b0;
                    state_next    = (action_t'(s_action) == ACT_RELEASE) ? S_RELEASE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || scan_miss) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                        if (hit) begin
                            slot_busy_next[cmp_idx_reg] = 1'b1;
                            m_slot_id_next = cmp_wide[ID_BITS-1:0];
                            m_status_next  = ST_REUSED;
                        end else if (used_reg == CntBits'(POOL_SLOTS)) begin
                            m_slot_id_next = '0;
                            m_status_next  = ST_FULL;
                        end else begin
                            ram_wr_en = 1'b1;
                            slot_busy_next[used_reg[IdxBits-1:0]] = 1'b1;
                            used_next      = used_reg + CntBits'(1);
                            m_slot_id_next = used_wide[ID_BITS-1:0];
                            m_status_next  = ST_CREATED;
                        end
                    end
                end else begin
                    // Issue the next slot read; it is compared in the next cycle.
                    ram_rd_en    = 1'b1;
                    cmp_idx_next = issue_reg[IdxBits-1:0];
                    pend_next    = 1'b1;
                    issue_next   = issue_reg + CntBits'(1);
                end
            end
            S_RELEASE: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    state_next     = S_IDLE;
                    m_slot_id_next = rel_slot_reg;
                    if (rel_ok) begin
                        slot_busy_next[rel_idx] = 1'b0;
                        m_status_next = ST_RELEASED;
                    end else begin
                        m_status_next = ST_BADREL;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Output word register.
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            slot_busy_reg <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            slot_busy_reg <= slot_busy_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
        issue_reg     <= issue_next;
        cmp_idx_reg   <= cmp_idx_next;
        m_slot_id_reg <= m_slot_id_next;
        m_status_reg  <= m_status_next;
        type_reg      <= type_next;
        dim0_reg      <= dim0_next;
        dim1_reg      <= dim1_next;
        rel_slot_reg  <= rel_slot_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_slot_id = m_slot_id_reg;
    assign m_status  = m_status_reg;

    // The slot count never passes the pool size.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CntBits'(POOL_SLOTS))
        else $error("slot count beyond pool size");

    // A created word always comes with one more slot in use.
    a_create_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (m_status_next == ST_CREATED)) |=>
        (used_reg == $past(used_reg) + CntBits'(1)))
        else $error("created word without slot count increment");

    // A released word leaves its slot idle.
    a_release_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (m_status_next == ST_RELEASED)) |=>
        !slot_busy_reg[$past(rel_idx)])
        else $error("released slot still busy");

    // A pending compare always refers to a created slot.
    a_pend_index: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (cmp_wide < used_wide))
        else $error("compare of a slot not yet created");

endmodule

`default_nettype wire

>>> verif/scratch_buffer_pool_checker.sv
// Checker for the scratch buffer pool core: watches both word channels, keeps its own
// copy of the pool and compares every result word with the predicted one.
// Depends on sbp_pkg for the action and status codes.
`timescale 1ns / 1ps

module scratch_buffer_pool_checker #(
    parameter int POOL_SLOTS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire logic                             s_action,
    input  wire logic [sbp_pkg::TYPE_BITS-1:0]    s_elem_type,
    input  wire logic [sbp_pkg::IN_DIM_BITS-1:0]  s_req_dim0,
    input  wire logic [sbp_pkg::IN_DIM_BITS-1:0]  s_req_dim1,
    input  wire logic [sbp_pkg::ID_BITS-1:0]      s_release_slot,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire logic [sbp_pkg::ID_BITS-1:0]      m_slot_id,
    input  wire logic [sbp_pkg::STATUS_BITS-1:0]  m_status,
    output int                                    outstanding,
    output int                                    failures
);
    import sbp_pkg::*;

    typedef struct packed {
        logic [ID_BITS-1:0] slot_id;
        status_t            status;
    } pool_reply_t;

    // Shadow copy of the pool.
    int                     slots_created;
    bit                     slot_held  [POOL_SLOTS];
    logic [TYPE_BITS-1:0]   slot_kind  [POOL_SLOTS];
    logic [IN_DIM_BITS-1:0] slot_size0 [POOL_SLOTS];
    logic [IN_DIM_BITS-1:0] slot_size1 [POOL_SLOTS];

    pool_reply_t pending_replies[$];

    // Applies one request word to the shadow pool and returns the reply it must cause.
    function automatic pool_reply_t predict_reply(action_t act, logic [TYPE_BITS-1:0] kind,
                                                  logic [IN_DIM_BITS-1:0] d0,
                                                  logic [IN_DIM_BITS-1:0] d1,
                                                  logic [ID_BITS-1:0] rel);
        pool_reply_t reply;
        int i;
        if (act == ACT_ACQUIRE) begin
            // First fit among the idle slots of the same type.
            for (i = 0; i < slots_created; i++) begin
                if (!slot_held[i] && slot_kind[i] == kind &&
                    slot_size0[i] >= d0 && slot_size1[i] >= d1) begin
                    slot_held[i]  = 1'b1;
                    reply.slot_id = i[ID_BITS-1:0];
                    reply.status  = ST_REUSED;
                    return reply;
                end
            end
            if (slots_created >= POOL_SLOTS) begin
                reply.slot_id = '0;
                reply.status  = ST_FULL;
                return reply;
            end
            // Nothing fits, so a new slot is appended.
            slot_kind[slots_created]  = kind;
            slot_size0[slots_created] = d0;
            slot_size1[slots_created] = d1;
            slot_held[slots_created]  = 1'b1;
            reply.slot_id = slots_created[ID_BITS-1:0];
            reply.status  = ST_CREATED;
            slots_created++;
            return reply;
        end
        // A release is only valid for a created slot that is currently held.
        reply.slot_id = rel;
        if (int'(rel) < slots_created && slot_held[rel]) begin
            slot_held[rel] = 1'b0;
            reply.status   = ST_RELEASED;
        end else begin
            reply.status   = ST_BADREL;
        end
        return reply;
    endfunction

    // Compare accepted result words first, then queue the prediction for a new request.
    always @(posedge aclk) begin : watch
        pool_reply_t want;
        int i;
        if (!aresetn) begin
            slots_created = 0;
            for (i = 0; i < POOL_SLOTS; i++) begin
                slot_held[i] = 1'b0;
            end
            pending_replies.delete();
            failures    <= 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    if (failures < 10) begin
                        $display("mismatch: unexpected result word slot_id=%0d status=%0d",
                                 m_slot_id, m_status);
                    end
                    failures <= failures + 1;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_slot_id !== want.slot_id || m_status !== want.status) begin
                        if (failures < 10) begin
                            $display({"mismatch: expected slot_id=%0d status=%0d, ",
                                      "got slot_id=%0d status=%0d"},
                                     want.slot_id, want.status, m_slot_id, m_status);
                        end
                        failures <= failures + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_replies = {pending_replies,
                                   predict_reply(action_t'(s_action), s_elem_type,
                                                 s_req_dim0, s_req_dim1,
                                                 s_release_slot)};
            end
            outstanding <= pending_replies.size();
        end
    end

endmodule

>>> verif/scratch_buffer_pool_core_test.sv
// Top of the scratch buffer pool testbench: clock, reset, request and result traffic.
// Depends on sbp_pkg, scratch_buffer_pool_core and scratch_buffer_pool_checker.
`timescale 1ns / 1ps

module scratch_buffer_pool_core_test;
    import sbp_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 400;
    localparam int HOLD_CYCLES  = 300;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_action       = 1'b0;
    logic [TYPE_BITS-1:0]   s_elem_type    = '0;
    logic [IN_DIM_BITS-1:0] s_req_dim0     = '0;
    logic [IN_DIM_BITS-1:0] s_req_dim1     = '0;
    logic [ID_BITS-1:0]     s_release_slot = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [ID_BITS-1:0]     m_slot_id;
    logic [STATUS_BITS-1:0] m_status;

    int outstanding;
    int failures;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req  = 1'b0;

    scratch_buffer_pool_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_elem_type    (s_elem_type),
        .s_req_dim0     (s_req_dim0),
        .s_req_dim1     (s_req_dim1),
        .s_release_slot (s_release_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_id      (m_slot_id),
        .m_status       (m_status)
    );

    scratch_buffer_pool_checker pool_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_elem_type    (s_elem_type),
        .s_req_dim0     (s_req_dim0),
        .s_req_dim1     (s_req_dim1),
        .s_release_slot (s_release_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_id      (m_slot_id),
        .m_status       (m_status),
        .outstanding    (outstanding),
        .failures       (failures)
    );

    // Free-running clock with a 4 ns period.
    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure, or one long hold-off when it is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one request word, after random idle cycles, and waits until it is taken.
    task automatic send_word(action_t act, logic [TYPE_BITS-1:0] kind,
                             logic [IN_DIM_BITS-1:0] d0, logic [IN_DIM_BITS-1:0] d1,
                             logic [ID_BITS-1:0] rel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_elem_type    <= kind;
        s_req_dim0     <= d0;
        s_req_dim1     <= d1;
        s_release_slot <= rel;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The fields that do not belong to the action carry random values.
    task automatic acquire(logic [TYPE_BITS-1:0] kind, logic [IN_DIM_BITS-1:0] d0,
                           logic [IN_DIM_BITS-1:0] d1);
        send_word(ACT_ACQUIRE, kind, d0, d1, ID_BITS'($urandom_range(15)));
    endtask

    task automatic release_slot(logic [ID_BITS-1:0] rel);
        send_word(ACT_RELEASE, TYPE_BITS'($urandom_range(15)),
                  IN_DIM_BITS'($urandom_range(65535)),
                  IN_DIM_BITS'($urandom_range(65535)), rel);
    endtask

    // Stops offering words until every predicted result word has been taken.
    task automatic drain();
        do begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    // Acquires of a few types and modest sizes so that slots get reused,
    // with fully random requests and releases of any slot mixed in.
    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            acquire(TYPE_BITS'($urandom_range(3)), IN_DIM_BITS'($urandom_range(1500)),
                    IN_DIM_BITS'($urandom_range(1500)));
        end else if (pick < 55) begin
            acquire(TYPE_BITS'($urandom_range(15)), IN_DIM_BITS'($urandom_range(65535)),
                    IN_DIM_BITS'($urandom_range(65535)));
        end else begin
            release_slot(ID_BITS'($urandom_range(15)));
        end
    endtask

    initial begin : stimulus
        int k;
        int n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 32;
        recv_idle_pct = 61;

        // Directed part: releases before any slot exists and of an idle slot,
        // reuse at the extreme sizes, near misses on size, and a full pool.
        release_slot(4'd0);
        acquire(4'd15, 16'hffff, 16'hffff);
        acquire(4'd15, 16'h0000, 16'h0000);
        release_slot(4'd0);
        release_slot(4'd0);
        acquire(4'd15, 16'hffff, 16'hffff);
        acquire(4'd0, 16'h0000, 16'h0000);
        release_slot(4'd2);
        acquire(4'd0, 16'h0001, 16'h0000);
        acquire(4'd0, 16'h0000, 16'h0000);
        release_slot(4'd15);
        for (k = 4; k < 16; k++) begin
            acquire(TYPE_BITS'(k % 4), IN_DIM_BITS'(k * 200), IN_DIM_BITS'(3000 - k * 150));
        end
        acquire(4'd9, 16'h0001, 16'h0001);
        drain();

        // Random part in three phases of idling.
        for (n = 0; n < RANDOM_WORDS / 3; n++) begin
            random_word();
        end
        drain();
        send_idle_pct = 61;
        recv_idle_pct = 32;
        for (n = 0; n < RANDOM_WORDS / 3; n++) begin
            random_word();
        end
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        for (n = 0; n < RANDOM_WORDS - 2 * (RANDOM_WORDS / 3); n++) begin
            random_word();
        end
        drain();

        repeat (40) @(posedge aclk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
